### sv/bmm_pkg.sv
// Shared types and codes for the bipartite matching block.
package bmm_pkg;

  localparam int FW = 6;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [1:0] STAT_ACCEPT = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_ENTRY  = 2'd2;

  localparam int CIW = 2;
  localparam logic [CIW-1:0] REG_LEFT_COUNT  = 2'd0;
  localparam logic [CIW-1:0] REG_RIGHT_COUNT = 2'd1;

  typedef struct packed {
    logic [1:0]    operation;
    logic [FW-1:0] left_vertex;
    logic [FW-1:0] right_vertex;
  } item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [FW-1:0] vertex_index;
    logic [FW-1:0] partner;
    logic [FW-1:0] matching_size;
    logic          last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BINIT,
    ST_BPOP,
    ST_BLOAD,
    ST_BEDGE,
    ST_ASCAN,
    ST_ALOAD,
    ST_AEDGE,
    ST_AFAIL,
    ST_ASKIP,
    ST_ASKIP2,
    ST_AUNW,
    ST_AUNW2,
    ST_OUT
  } state_t;

endpackage

### sv/bipartite_max_matching.sv
// Top level: ports, configuration registers, edge load control and result register.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   item     | item_valid / item_ready     | operation, left/right vertex
//   result   | result_valid / result_ready | status, vertex, partner, size
//   cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// Edge add and clear update the store when accepted; an add transaction follows the previous one
// in the next cycle while the result register drains.
// A run walks the stored edges of each phase through the single read port of the
// edge memories; results then leave at one per cycle unless result_ready holds
// them back.
// Reset clears the edge store through per-vertex valid bits; no clearing pass.
// item_ready drops while a run is busy or a result waits unaccepted.
module bipartite_max_matching #(
  parameter int MAX_LEFT  = 32,
  parameter int MAX_RIGHT = 32,
  parameter int MAX_EDGES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  bmm_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output bmm_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmm_pkg::CIW-1:0]       cfg_index,
  input  logic [bmm_pkg::FW-1:0]        cfg_data
);
  import bmm_pkg::*;

  localparam int VW = $clog2(MAX_LEFT + 1);
  localparam int RW = $clog2(MAX_RIGHT + 1);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [FW-1:0] left_count, right_count;
  logic [VW-1:0] run_lc, core_look, look_u;
  logic [RW-1:0] run_rc, tgt_q;
  logic [EW-1:0] hd_head, hd_tail, rd_addr, link_q;
  logic          hd_valid, full, busy, accept, bad, add, clear, start, res_free;
  logic          core_valid;
  result_t       core_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEFT_COUNT:  left_count  <= cfg_data;
        REG_RIGHT_COUNT: right_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign res_free   = !result_valid || result_ready;
  assign item_ready = !busy && res_free;
  assign accept     = item_valid && item_ready;

  assign bad = (item.left_vertex == '0) || (item.left_vertex > left_count) ||
               ({1'b0, item.left_vertex} > (FW+1)'(MAX_LEFT)) ||
               (item.right_vertex == '0) || (item.right_vertex > right_count) ||
               ({1'b0, item.right_vertex} > (FW+1)'(MAX_RIGHT)) || full;

  assign add   = accept && (item.operation == OP_ADD) && !bad;
  assign clear = accept && (item.operation == OP_CLEAR);
  assign start = accept && (item.operation == OP_RUN);

  assign run_lc = ({1'b0, left_count} > (FW+1)'(MAX_LEFT)) ? VW'(MAX_LEFT) : VW'(left_count);
  assign run_rc = ({1'b0, right_count} > (FW+1)'(MAX_RIGHT)) ? RW'(MAX_RIGHT) :
                  RW'(right_count);

  // list lookup follows the sequencer during a run, the incoming edge otherwise
  assign look_u = busy ? core_look : VW'(item.left_vertex);

  bmm_store #(
    .MAX_LEFT (MAX_LEFT),
    .MAX_RIGHT(MAX_RIGHT),
    .MAX_EDGES(MAX_EDGES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear),
    .add     (add),
    .add_v   (RW'(item.right_vertex)),
    .full    (full),
    .look_u  (look_u),
    .hd_head (hd_head),
    .hd_tail (hd_tail),
    .hd_valid(hd_valid),
    .rd_addr (rd_addr),
    .tgt_q   (tgt_q),
    .link_q  (link_q)
  );

  bmm_core #(
    .MAX_LEFT (MAX_LEFT),
    .MAX_RIGHT(MAX_RIGHT),
    .MAX_EDGES(MAX_EDGES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .run_lc   (run_lc),
    .run_rc   (run_rc),
    .busy     (busy),
    .look_u   (core_look),
    .hd_head  (hd_head),
    .hd_tail  (hd_tail),
    .hd_valid (hd_valid),
    .rd_addr  (rd_addr),
    .tgt_q    (tgt_q),
    .link_q   (link_q),
    .res_valid(core_valid),
    .res_ready(res_free),
    .res      (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((accept && item.operation == OP_ADD) || (core_valid && res_free)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.operation == OP_ADD) begin
      result.status        <= bad ? STAT_REJECT : STAT_ACCEPT;
      result.vertex_index  <= '0;
      result.partner       <= '0;
      result.matching_size <= '0;
      result.last          <= 1'b1;
    end else if (core_valid && res_free) begin
      result <= core_res;
    end
  end

endmodule

### sv/bmm_store.sv
// Edge store: target and link memories plus per-vertex list head and tail.
module bmm_store #(
  parameter int MAX_LEFT,
  parameter int MAX_RIGHT,
  parameter int MAX_EDGES
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          clear,
  input  logic                                          add,
  input  logic [$clog2(MAX_RIGHT+1)-1:0]                add_v,
  output logic                                          full,
  input  logic [$clog2(MAX_LEFT+1)-1:0]                 look_u,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] hd_head,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] hd_tail,
  output logic                                          hd_valid,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr,
  output logic [$clog2(MAX_RIGHT+1)-1:0]                tgt_q,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] link_q
);
  import bmm_pkg::*;

  localparam int VW = $clog2(MAX_LEFT + 1);
  localparam int RW = $clog2(MAX_RIGHT + 1);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);

  logic [RW-1:0] edge_target [0:MAX_EDGES-1];
  logic [EW-1:0] edge_link   [0:MAX_EDGES-1];
  logic [EW-1:0] list_head   [1:MAX_LEFT];
  logic [EW-1:0] list_tail   [1:MAX_LEFT];
  logic          head_valid  [1:MAX_LEFT];
  logic [CW-1:0] edge_total;
  logic [EW-1:0] new_idx;
  logic          in_range;

  assign new_idx  = edge_total[EW-1:0];
  assign full     = (edge_total == CW'(MAX_EDGES));
  assign in_range = (look_u != '0) && ({1'b0, look_u} <= (VW+1)'(MAX_LEFT));
  assign hd_valid = in_range && head_valid[look_u];
  assign hd_head  = list_head[look_u];
  assign hd_tail  = list_tail[look_u];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      edge_total <= '0;
      for (int k = 1; k <= MAX_LEFT; k++) head_valid[k] <= 1'b0;
    end else if (add) begin
      edge_total <= edge_total + 1'b1;
      head_valid[look_u] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (add) begin
      if (!hd_valid) list_head[look_u] <= new_idx;
      list_tail[look_u] <= new_idx;
    end
  end

  // append: new edge goes behind the current tail
  always_ff @(posedge clk) begin
    if (add) begin
      edge_target[new_idx] <= add_v;
      if (hd_valid) edge_link[hd_tail] <= new_idx;
    end
    tgt_q  <= edge_target[rd_addr];
    link_q <= edge_link[rd_addr];
  end

endmodule

### sv/bmm_core.sv
// Matching sequencer: layered search, stack-driven augmentation, result walk.
module bmm_core #(
  parameter int MAX_LEFT,
  parameter int MAX_RIGHT,
  parameter int MAX_EDGES
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [$clog2(MAX_LEFT+1)-1:0]                 run_lc,
  input  logic [$clog2(MAX_RIGHT+1)-1:0]                run_rc,
  output logic                                          busy,
  output logic [$clog2(MAX_LEFT+1)-1:0]                 look_u,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] hd_head,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] hd_tail,
  input  logic                                          hd_valid,
  output logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr,
  input  logic [$clog2(MAX_RIGHT+1)-1:0]                tgt_q,
  input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] link_q,
  output logic                                          res_valid,
  input  logic                                          res_ready,
  output bmm_pkg::result_t                              res
);
  import bmm_pkg::*;

  localparam int VW = $clog2(MAX_LEFT + 1);
  localparam int RW = $clog2(MAX_RIGHT + 1);
  localparam int DW = $clog2(MAX_LEFT + 2);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int QW = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
  localparam logic [DW-1:0] INF = DW'(MAX_LEFT + 1);

  state_t state, state_next;

  logic [DW-1:0] i, qh, qt, lay0, cur_lay;
  logic [VW-1:0] sp, cur_u, pair;
  logic [EW-1:0] fe;

  logic [DW-1:0] lay   [1:MAX_LEFT];
  logic [RW-1:0] lp    [1:MAX_LEFT];
  logic [VW-1:0] rp    [1:MAX_RIGHT];
  logic [VW-1:0] queue [0:MAX_LEFT-1];
  logic [VW-1:0] stk_u [0:MAX_LEFT-1];
  logic [EW-1:0] stk_e [0:MAX_LEFT-1];
  logic [DW-1:0] stk_l [0:MAX_LEFT-1];

  logic [VW-1:0] i_v, w, sp_m1;
  logic [RW-1:0] lp_i;
  logic [DW-1:0] lw, lay_up;
  logic          i_over, i_last, v_ok, match, at_tail, can_push;

  assign busy     = (state != ST_IDLE);
  assign look_u   = cur_u;
  assign i_v      = VW'(i);
  assign i_over   = (i > DW'(run_lc));
  assign i_last   = (i == DW'(run_lc));
  assign lp_i     = lp[i_v];
  assign v_ok     = (tgt_q != '0) && (tgt_q <= run_rc);
  assign w        = v_ok ? rp[tgt_q] : '0;
  assign lw       = (w == '0) ? lay0 : lay[w];
  assign lay_up   = cur_lay + 1'b1;
  // compare one bit wider so an unreachable layer never wraps onto a match
  assign match    = v_ok && ({1'b0, lw} == ({1'b0, cur_lay} + (DW+1)'(1)));
  assign at_tail  = (fe == hd_tail);
  assign can_push = (sp < VW'(MAX_LEFT - 1));
  assign sp_m1    = sp - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = fe;
    res_valid  = 1'b0;
    res        = '0;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_BINIT;
      end
      ST_BINIT: begin
        if (i_over) state_next = ST_BPOP;
      end
      ST_BPOP: begin
        if (qh < qt) state_next = ST_BLOAD;
        else if (lay0 != INF) state_next = ST_ASCAN;
        else state_next = ST_OUT;
      end
      ST_BLOAD: begin
        rd_addr    = hd_head;
        state_next = hd_valid ? ST_BEDGE : ST_BPOP;
      end
      ST_BEDGE: begin
        rd_addr = link_q;
        if (at_tail) state_next = ST_BPOP;
      end
      ST_ASCAN: begin
        if (i_over) state_next = ST_BINIT;
        else if (lp_i == '0) state_next = ST_ALOAD;
      end
      ST_ALOAD: begin
        rd_addr    = hd_head;
        state_next = hd_valid ? ST_AEDGE : ST_AFAIL;
      end
      ST_AEDGE: begin
        rd_addr = link_q;
        if (match && w == '0) state_next = (sp == '0) ? ST_ASCAN : ST_AUNW;
        else if (match && can_push) state_next = ST_ALOAD;
        else if (at_tail) state_next = ST_AFAIL;
      end
      ST_AFAIL: begin
        state_next = (sp == '0) ? ST_ASCAN : ST_ASKIP;
      end
      ST_ASKIP: begin
        state_next = at_tail ? ST_AFAIL : ST_ASKIP2;
      end
      ST_ASKIP2: begin
        rd_addr    = link_q;
        state_next = ST_AEDGE;
      end
      ST_AUNW: begin
        state_next = ST_AUNW2;
      end
      ST_AUNW2: begin
        state_next = (sp == '0) ? ST_ASCAN : ST_AUNW;
      end
      ST_OUT: begin
        res_valid          = 1'b1;
        res.status         = STAT_ENTRY;
        res.vertex_index   = (run_lc == '0) ? '0 : FW'(i);
        res.partner        = (run_lc == '0) ? '0 : FW'(lp_i);
        res.last           = (run_lc == '0) || i_last;
        res.matching_size  = res.last ? FW'(pair) : '0;
        if (res_ready && res.last) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          i    <= DW'(1);
          qt   <= '0;
          pair <= '0;
          lay0 <= '0;
          for (int k = 1; k <= MAX_LEFT; k++) begin
            lp[k]  <= '0;
            lay[k] <= '0;
          end
          for (int k = 1; k <= MAX_RIGHT; k++) rp[k] <= '0;
        end
      end
      ST_BINIT: begin
        if (!i_over) begin
          lay[i_v] <= (lp_i == '0) ? '0 : INF;
          if (lp_i == '0) begin
            queue[qt[QW-1:0]] <= i_v;
            qt <= qt + 1'b1;
          end
          i <= i + 1'b1;
        end else begin
          lay0 <= INF;
          qh   <= '0;
        end
      end
      ST_BPOP: begin
        i <= DW'(1);
        if (qh < qt) begin
          cur_u <= queue[qh[QW-1:0]];
          qh    <= qh + 1'b1;
        end
      end
      ST_BLOAD, ST_ALOAD: begin
        cur_lay <= lay[cur_u];
        fe      <= hd_head;
      end
      ST_BEDGE: begin
        if (v_ok && lw == INF) begin
          if (w == '0) lay0 <= lay_up;
          else lay[w] <= lay_up;
          if (w != '0 && qt < DW'(MAX_LEFT)) begin
            queue[qt[QW-1:0]] <= w;
            qt <= qt + 1'b1;
          end
        end
        if (!at_tail) fe <= link_q;
      end
      ST_ASCAN: begin
        if (i_over) begin
          i  <= DW'(1);
          qt <= '0;
        end else if (lp_i == '0) begin
          cur_u <= i_v;
          sp    <= '0;
        end else begin
          i <= i + 1'b1;
        end
      end
      ST_AEDGE: begin
        if (match && w == '0) begin
          rp[tgt_q] <= cur_u;
          lp[cur_u] <= tgt_q;
          if (sp == '0) begin
            pair <= pair + 1'b1;
            i    <= i + 1'b1;
          end else begin
            cur_u   <= stk_u[sp_m1[QW-1:0]];
            fe      <= stk_e[sp_m1[QW-1:0]];
            cur_lay <= stk_l[sp_m1[QW-1:0]];
            sp      <= sp_m1;
          end
        end else if (match && can_push) begin
          stk_u[sp[QW-1:0]] <= cur_u;
          stk_e[sp[QW-1:0]] <= fe;
          stk_l[sp[QW-1:0]] <= cur_lay;
          sp    <= sp + 1'b1;
          cur_u <= w;
        end else if (!at_tail) begin
          fe <= link_q;
        end
      end
      ST_AFAIL: begin
        lay[cur_u] <= INF;
        if (sp == '0) begin
          i <= i + 1'b1;
        end else begin
          cur_u   <= stk_u[sp_m1[QW-1:0]];
          fe      <= stk_e[sp_m1[QW-1:0]];
          cur_lay <= stk_l[sp_m1[QW-1:0]];
          sp      <= sp_m1;
        end
      end
      ST_ASKIP2: begin
        fe <= link_q;
      end
      ST_AUNW2: begin
        // flip the parent's edge along the found path
        rp[tgt_q] <= cur_u;
        lp[cur_u] <= tgt_q;
        if (sp == '0) begin
          pair <= pair + 1'b1;
          i    <= i + 1'b1;
        end else begin
          cur_u   <= stk_u[sp_m1[QW-1:0]];
          fe      <= stk_e[sp_m1[QW-1:0]];
          cur_lay <= stk_l[sp_m1[QW-1:0]];
          sp      <= sp_m1;
        end
      end
      ST_OUT: begin
        if (res_ready) i <= i + 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_BPOP |-> qt <= DW'(run_lc))
    else $error("search queue holds more vertices than the run uses");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> pair <= run_lc)
    else $error("matching size exceeds left vertex count");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_AEDGE |-> sp < VW'(MAX_LEFT))
    else $error("path stack overflow");

  a_push_depth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AEDGE && state_next == ST_ALOAD) |=>
      (state == ST_ALOAD && sp == $past(sp) + 1'b1))
    else $error("push did not deepen the stack");
`endif

endmodule

### tb/bipartite_max_matching_test.sv
// Self-checking testbench for the bipartite matching block: directed table, then random runs.
module bipartite_max_matching_test;
  import bmm_pkg::*;

  localparam int NL = 32;
  localparam int NR = 32;
  localparam int NE = 1024;
  localparam int NO_LAYER = NL + 1;
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 430;

  localparam result_t ACC = '{STAT_ACCEPT, 6'd0, 6'd0, 6'd0, 1'b1};
  localparam result_t REJ = '{STAT_REJECT, 6'd0, 6'd0, 6'd0, 1'b1};
  localparam result_t EMPTY_RUN = '{STAT_ENTRY, 6'd0, 6'd0, 6'd0, 1'b1};
  localparam result_t NA = '0;

  localparam logic [1:0] OP_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIW-1:0] cfg_index = '0;
  logic [FW-1:0] cfg_data = '0;

  bipartite_max_matching DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [5:0] left_cfg, right_cfg;
  int edge_dst[NE];
  int edge_next[NE];
  bit has_edges[NL+1];
  int first_edge[NL+1];
  int last_edge[NL+1];
  int edge_count;
  int match_l[NL+1];
  int match_r[NR+1];
  int layer[NL+1];
  int bfs_q[NL+2];
  int stk_u[NL];
  int stk_e[NL];
  bit stk_h[NL];
  int run_left, run_right;

  result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  function automatic void expect_result(result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic bit build_layers();
    int qh, qt, u, w, v, e;
    bit has;
    qh = 0;
    qt = 0;
    for (u = 1; u <= run_left; u++) begin
      if (match_l[u] == 0) begin
        layer[u] = 0;
        bfs_q[qt++] = u;
      end else begin
        layer[u] = NO_LAYER;
      end
    end
    layer[0] = NO_LAYER;
    while (qh < qt) begin
      u = bfs_q[qh++];
      e = first_edge[u];
      has = has_edges[u];
      while (has) begin
        v = edge_dst[e];
        if (v >= 1 && v <= run_right) begin
          w = match_r[v];
          if (layer[w] == NO_LAYER) begin
            layer[w] = layer[u] + 1;
            if (w != 0 && qt <= NL) bfs_q[qt++] = w;
          end
        end
        if (e == last_edge[u]) has = 0;
        else e = edge_next[e];
      end
    end
    return layer[0] != NO_LAYER;
  endfunction

  function automatic bit augment_from(int root);
    int sp, k, u, v, w;
    bit back, ok, moved;
    sp = 1;
    back = 0;
    ok = 0;
    stk_u[0] = root;
    stk_e[0] = first_edge[root];
    stk_h[0] = has_edges[root];
    while (sp > 0) begin
      k = sp - 1;
      u = stk_u[k];
      if (back) begin
        back = 0;
        if (ok) begin
          v = edge_dst[stk_e[k]];
          match_r[v] = u;
          match_l[u] = v;
          sp--;
          back = 1;
          continue;
        end
        if (stk_e[k] == last_edge[u]) stk_h[k] = 0;
        else stk_e[k] = edge_next[stk_e[k]];
      end
      moved = 0;
      while (stk_h[k] && !moved) begin
        v = edge_dst[stk_e[k]];
        if (v >= 1 && v <= run_right) begin
          w = match_r[v];
          if (layer[w] == layer[u] + 1) begin
            if (w == 0) begin
              match_r[v] = u;
              match_l[u] = v;
              sp--;
              ok = 1;
              back = 1;
              moved = 1;
            end else if (sp < NL) begin
              stk_u[sp] = w;
              stk_e[sp] = first_edge[w];
              stk_h[sp] = has_edges[w];
              sp++;
              moved = 1;
            end
          end
        end
        if (!moved) begin
          if (stk_e[k] == last_edge[u]) stk_h[k] = 0;
          else stk_e[k] = edge_next[stk_e[k]];
        end
      end
      if (!moved) begin
        layer[u] = NO_LAYER;
        sp--;
        ok = 0;
        back = 1;
      end
    end
    return ok;
  endfunction

  // Updates predictor state for one accepted transaction and queues its results.
  function automatic void predict_item(item_t it);
    int a, b, i, pairs;
    bit bad;
    result_t r;
    a = it.left_vertex;
    b = it.right_vertex;
    case (it.operation)
      OP_CLEAR: begin
        for (i = 0; i <= NL; i++) has_edges[i] = 0;
        edge_count = 0;
      end
      OP_ADD: begin
        bad = a == 0 || a > left_cfg || a > NL || b == 0 || b > right_cfg || b > NR ||
              edge_count >= NE;
        if (!bad) begin
          edge_dst[edge_count] = b;
          if (has_edges[a]) edge_next[last_edge[a]] = edge_count;
          else begin
            first_edge[a] = edge_count;
            has_edges[a] = 1;
          end
          last_edge[a] = edge_count;
          edge_count++;
        end
        expect_result(bad ? REJ : ACC);
      end
      OP_RUN: begin
        run_left = left_cfg > NL ? NL : left_cfg;
        run_right = right_cfg > NR ? NR : right_cfg;
        for (i = 0; i <= NL; i++) begin
          match_l[i] = 0;
          match_r[i] = 0;
          layer[i] = 0;
        end
        pairs = 0;
        while (build_layers()) begin
          for (i = 1; i <= run_left; i++)
            if (match_l[i] == 0 && augment_from(i)) pairs++;
        end
        if (run_left == 0) expect_result(EMPTY_RUN);
        for (i = 1; i <= run_left; i++) begin
          r.status = STAT_ENTRY;
          r.vertex_index = 6'(i);
          r.partner = 6'(match_l[i]);
          r.matching_size = (i == run_left) ? 6'(pairs) : 6'd0;
          r.last = (i == run_left);
          expect_result(r);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(item_t it, bit chk = 0, result_t want = NA);
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    predict_item(it);
    if (chk) pending_results[pending_results.size() - 1] = want;
    items_sent++;
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [FW-1:0] val);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a clear leaves no result behind, so give the block time to settle
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LEFT_COUNT) left_cfg = val;
    else right_cfg = val;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [FW-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'($urandom_range(33, 63));
      default: return 6'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // result check and watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result transaction", 1, 0);
        end else begin
          exp_r = pending_results.pop_front();
          if (result.status !== exp_r.status)
            flag_mismatch("status", result.status, exp_r.status);
          if (result.vertex_index !== exp_r.vertex_index)
            flag_mismatch("vertex_index", result.vertex_index, exp_r.vertex_index);
          if (result.partner !== exp_r.partner)
            flag_mismatch("partner", result.partner, exp_r.partner);
          if (result.matching_size !== exp_r.matching_size)
            flag_mismatch("matching_size", result.matching_size, exp_r.matching_size);
          if (result.last !== exp_r.last)
            flag_mismatch("last", result.last, exp_r.last);
        end
      end
      if ((result_valid && result_ready) || (item_valid && item_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** bipartite_max_matching: FAILED **");
        $finish;
      end
    end
  end

  typedef struct {
    bit is_cfg;
    logic [CIW-1:0] idx;
    logic [FW-1:0] val;
    item_t it;
    bit chk;
    result_t want;
  } row_t;

  row_t plan[25] = '{
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd1, 6'd1}, 1, REJ},     // counts still zero
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_RUN, 6'd0, 6'd0}, 1, EMPTY_RUN},
    '{1, REG_LEFT_COUNT, 6'd4, '{OP_NOP, 6'd0, 6'd0}, 0, NA},
    '{1, REG_RIGHT_COUNT, 6'd3, '{OP_NOP, 6'd0, 6'd0}, 0, NA},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd0, 6'd1}, 1, REJ},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd1, 6'd0}, 1, REJ},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd5, 6'd1}, 1, REJ},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd1, 6'd4}, 1, REJ},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd1, 6'd1}, 1, ACC},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd1, 6'd1}, 1, ACC},     // duplicate
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd2, 6'd1}, 1, ACC},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd2, 6'd2}, 1, ACC},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd3, 6'd2}, 1, ACC},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd4, 6'd3}, 1, ACC},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_NOP, 6'd63, 6'd63}, 0, NA},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_RUN, 6'd0, 6'd0}, 0, NA},
    '{1, REG_RIGHT_COUNT, 6'd1, '{OP_NOP, 6'd0, 6'd0}, 0, NA},     // stale right vertices
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_RUN, 6'd0, 6'd0}, 0, NA},
    '{1, REG_LEFT_COUNT, 6'd63, '{OP_NOP, 6'd0, 6'd0}, 0, NA},     // clamped counts
    '{1, REG_RIGHT_COUNT, 6'd63, '{OP_NOP, 6'd0, 6'd0}, 0, NA},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd63, 6'd63}, 1, REJ},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_ADD, 6'd32, 6'd32}, 1, ACC},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_RUN, 6'd0, 6'd0}, 0, NA},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_CLEAR, 6'd0, 6'd0}, 0, NA},
    '{0, REG_LEFT_COUNT, 6'd0, '{OP_RUN, 6'd0, 6'd0}, 0, NA}
  };

  initial begin
    int i, n, lim_l, lim_r, base;
    bit first_phase;
    item_t it;
    left_cfg = 0;
    right_cfg = 0;
    edge_count = 0;
    for (i = 0; i <= NL; i++) has_edges[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) write_reg(plan[k].idx, plan[k].val);
      else send_item(plan[k].it, plan[k].chk, plan[k].want);
    end

    base = items_sent;
    first_phase = 1;
    while (items_sent - base < RANDOM_ITEMS) begin
      write_reg(REG_LEFT_COUNT, pick_count());
      write_reg(REG_RIGHT_COUNT, pick_count());
      if (items_sent - base > RANDOM_ITEMS - 80) calm = 1'b1;
      lim_l = left_cfg > NL ? NL : left_cfg;
      lim_r = right_cfg > NR ? NR : right_cfg;
      if ($urandom_range(0, 3) != 0) send_item('{OP_CLEAR, 6'd0, 6'd0});
      if (first_phase) hold_req = 1'b1;
      n = first_phase ? 30 : $urandom_range(0, 40);
      first_phase = 0;
      for (i = 0; i < n; i++) begin
        it.operation = OP_ADD;
        it.left_vertex = (lim_l > 0 && $urandom_range(0, 9) != 0) ?
                         6'($urandom_range(1, lim_l)) : 6'($urandom_range(0, 63));
        it.right_vertex = (lim_r > 0 && $urandom_range(0, 9) != 0) ?
                          6'($urandom_range(1, lim_r)) : 6'($urandom_range(0, 63));
        if ($urandom_range(0, 19) == 0) it.operation = 2'($urandom_range(0, 3));
        send_item(it);
      end
      send_item('{OP_RUN, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))});
    end

    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("** bipartite_max_matching: PASSED **");
    else $display("** bipartite_max_matching: FAILED **");
    $finish;
  end

endmodule

### files.f
sv/bmm_pkg.sv
sv/bmm_store.sv
sv/bmm_core.sv
sv/bipartite_max_matching.sv
tb/bipartite_max_matching_test.sv
